### rtl/dgbf_pkg.sv
// Shared constants, types and sequencer states of the shortest-path graph engine.
`timescale 1ns / 1ps

package dgbf_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_DEGREE   = 16;

  localparam int VID_W   = $clog2(MAX_VERTICES);
  localparam int VT_W    = $clog2(MAX_VERTICES + 1);
  localparam int SLOT_W  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
  localparam int ADJ_AW  = VID_W + SLOT_W;
  localparam int W_W     = 21;
  localparam int DIST_W  = 31;
  localparam int ROUND_W = 11;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 2;

  localparam logic signed [DIST_W-1:0] DIST_UNREACHED = 31'sd1073741823;
  localparam logic signed [DIST_W-1:0] DIST_NEGATIVE  = -31'sd1073741823;

  localparam logic [KIND_W-1:0] KIND_RUN    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_E  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REM_E  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADD_V  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd5;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic signed [W_W-1:0] weight;
    logic [VID_W-1:0]      id;
  } adj_entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_E_DEG, S_E_FIND, S_E_FIND_W, S_E_DECIDE, S_E_UP, S_E_UP_W, S_E_DN, S_E_DN_W,
    S_RD_W,
    S_R_INIT, S_R_ROUND, S_R_NEG, S_R_SCAN, S_R_SCAN_W, S_R_EDGE, S_R_EDGE_W,
    S_R_LOAD, S_R_SUM, S_R_CMP, S_R_SWAP, S_R_SWAP_W,
    S_DONE
  } state_t;

endpackage

### rtl/dynamic_graph_bellman_ford_sssp_top.sv
// Graph store with adjacency-list edits and a frontier Bellman-Ford shortest-path sequencer.
//
//   Channel | Direction | Handshake          | Contents
//   s       | in        | s_tvalid/s_tready  | tuser: kind; tdata: from, to, weight
//   m       | out       | m_tvalid/m_tready  | tuser: status; tdata: distance, rounds, flag
//
// One word is taken at a time; s_tready is high only while the sequencer is idle.
// Edits walk the sorted adjacency list of the from vertex; a run initializes every vertex, then
// each round scans the frontier and relaxes its edges one at a time through the one shared adder.
// Reset clears only control state; memories above the vertex count are never read.
// A finished word waits in the output register; the next item may be taken meanwhile.
`timescale 1ns / 1ps

module dynamic_graph_bellman_ford_sssp_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [9:0] from_vertex, [19:10] to_vertex, [40:20] edge_weight
  input  logic [2:0]  s_tuser,   // [2:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [30:0] distance, [41:31] rounds, [42] negative_cycle
  output logic [1:0]  m_tuser    // [1:0] status
);

  dgbf_pkg::state_t state, state_next;

  // Latched item.
  logic [dgbf_pkg::KIND_W-1:0]       kind_r;
  logic [dgbf_pkg::VID_W-1:0]        from_r;
  logic [dgbf_pkg::VID_W-1:0]        to_r;
  logic signed [dgbf_pkg::W_W-1:0]   weight_r;

  // Sequencer datapath.
  logic [dgbf_pkg::VT_W-1:0]         vertex_total;
  logic [dgbf_pkg::VT_W-1:0]         i_cnt;
  logic [dgbf_pkg::DEG_W-1:0]        k_cnt;
  logic [dgbf_pkg::DEG_W-1:0]        deg_r;
  logic [dgbf_pkg::DEG_W-1:0]        pos_r;
  logic                              match_r;
  logic [dgbf_pkg::VID_W-1:0]        d_r;
  logic signed [dgbf_pkg::W_W-1:0]   w_r;
  logic signed [dgbf_pkg::DIST_W-1:0] cand_r;
  logic [dgbf_pkg::ROUND_W-1:0]      round_r;
  logic                              any_next;
  logic [dgbf_pkg::STAT_W-1:0]       status_r;
  logic signed [dgbf_pkg::DIST_W-1:0] dist_r;
  logic [dgbf_pkg::ROUND_W-1:0]      last_rounds;
  logic                              last_cycle;

  // Output register.
  logic                              out_valid;
  logic [dgbf_pkg::STAT_W-1:0]       out_status;
  logic signed [dgbf_pkg::DIST_W-1:0] out_dist;
  logic [dgbf_pkg::ROUND_W-1:0]      out_rounds;
  logic                              out_flag;

  // Memories.
  logic [dgbf_pkg::DEG_W-1:0]  deg_mem   [dgbf_pkg::MAX_VERTICES];
  dgbf_pkg::adj_entry_t        adj_mem   [dgbf_pkg::MAX_VERTICES * dgbf_pkg::MAX_DEGREE];
  logic signed [dgbf_pkg::DIST_W-1:0] dist_mem [dgbf_pkg::MAX_VERTICES];
  logic                        front_mem [dgbf_pkg::MAX_VERTICES];
  logic                        join_mem  [dgbf_pkg::MAX_VERTICES];

  logic                        deg_we, adj_we, dist_we, front_we, join_we;
  logic [dgbf_pkg::VID_W-1:0]  deg_wa, deg_ra, dist_wa, front_wa, join_wa, join_ra;
  logic [dgbf_pkg::DEG_W-1:0]  deg_wd, deg_q;
  logic [dgbf_pkg::ADJ_AW-1:0] adj_wa, adj_ra;
  dgbf_pkg::adj_entry_t        adj_wd, adj_q;
  logic signed [dgbf_pkg::DIST_W-1:0] dist_wd, dist_a_q, dist_b_q;
  logic                        front_wd, front_q, join_wd, join_q;

  logic                        in_fire, from_ok, to_ok, running, last_i;
  logic [dgbf_pkg::VID_W-1:0]  vidx, list_v;
  logic [dgbf_pkg::DEG_W-1:0]  rd_slot;
  logic signed [dgbf_pkg::DIST_W:0] sum;
  logic signed [dgbf_pkg::DIST_W-1:0] sum_sat;

  assign in_fire = s_tvalid && s_tready;
  assign s_tready = (state == dgbf_pkg::S_IDLE);
  assign from_ok = {1'b0, from_r} < vertex_total;
  assign to_ok   = {1'b0, to_r} < vertex_total;
  assign running = (kind_r == dgbf_pkg::KIND_RUN);
  assign vidx    = i_cnt[dgbf_pkg::VID_W-1:0];
  assign last_i  = (i_cnt == vertex_total - 1'b1);
  assign list_v  = running ? vidx : from_r;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {5'd0, out_flag, out_rounds, out_dist};

  // Shared adder and saturation for the relaxation step.
  assign sum = {dist_a_q[dgbf_pkg::DIST_W-1], dist_a_q}
             + {{(dgbf_pkg::DIST_W + 1 - dgbf_pkg::W_W){w_r[dgbf_pkg::W_W-1]}}, w_r};
  always_comb begin
    if (sum > $signed({1'b0, dgbf_pkg::DIST_UNREACHED})) begin
      sum_sat = dgbf_pkg::DIST_UNREACHED;
    end else if (sum < $signed({1'b1, dgbf_pkg::DIST_NEGATIVE})) begin
      sum_sat = dgbf_pkg::DIST_NEGATIVE;
    end else begin
      sum_sat = sum[dgbf_pkg::DIST_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      dgbf_pkg::S_IDLE: if (s_tvalid) state_next = dgbf_pkg::S_DISPATCH;
      dgbf_pkg::S_DISPATCH: begin
        case (kind_r)
          dgbf_pkg::KIND_RUN:   state_next = from_ok ? dgbf_pkg::S_R_INIT : dgbf_pkg::S_DONE;
          dgbf_pkg::KIND_ADD_E,
          dgbf_pkg::KIND_REM_E: state_next = (from_ok && to_ok) ? dgbf_pkg::S_E_DEG
                                                                 : dgbf_pkg::S_DONE;
          dgbf_pkg::KIND_READ:  state_next = from_ok ? dgbf_pkg::S_RD_W : dgbf_pkg::S_DONE;
          default:              state_next = dgbf_pkg::S_DONE;
        endcase
      end
      dgbf_pkg::S_E_DEG:    state_next = dgbf_pkg::S_E_FIND;
      dgbf_pkg::S_E_FIND:   state_next = (k_cnt == deg_r) ? dgbf_pkg::S_E_DECIDE
                                                          : dgbf_pkg::S_E_FIND_W;
      dgbf_pkg::S_E_FIND_W: state_next = (to_r <= adj_q.id) ? dgbf_pkg::S_E_DECIDE
                                                            : dgbf_pkg::S_E_FIND;
      dgbf_pkg::S_E_DECIDE: begin
        if (kind_r == dgbf_pkg::KIND_ADD_E) begin
          state_next = (match_r || deg_r == dgbf_pkg::DEG_W'(dgbf_pkg::MAX_DEGREE))
                     ? dgbf_pkg::S_DONE : dgbf_pkg::S_E_UP;
        end else begin
          state_next = match_r ? dgbf_pkg::S_E_DN : dgbf_pkg::S_DONE;
        end
      end
      dgbf_pkg::S_E_UP:   state_next = (k_cnt == pos_r) ? dgbf_pkg::S_DONE : dgbf_pkg::S_E_UP_W;
      dgbf_pkg::S_E_UP_W: state_next = dgbf_pkg::S_E_UP;
      dgbf_pkg::S_E_DN:   state_next = (k_cnt + 1'b1 == deg_r) ? dgbf_pkg::S_DONE
                                                               : dgbf_pkg::S_E_DN_W;
      dgbf_pkg::S_E_DN_W: state_next = dgbf_pkg::S_E_DN;
      dgbf_pkg::S_RD_W:   state_next = dgbf_pkg::S_DONE;
      dgbf_pkg::S_R_INIT: if (last_i) state_next = dgbf_pkg::S_R_ROUND;
      dgbf_pkg::S_R_ROUND: begin
        state_next = ({1'b0, round_r} + 1'b1 == {1'b0, vertex_total}) ? dgbf_pkg::S_R_NEG
                                                                       : dgbf_pkg::S_R_SCAN;
      end
      dgbf_pkg::S_R_NEG:    if (last_i) state_next = dgbf_pkg::S_DONE;
      dgbf_pkg::S_R_SCAN:   state_next = (i_cnt == vertex_total) ? dgbf_pkg::S_R_SWAP
                                                                 : dgbf_pkg::S_R_SCAN_W;
      dgbf_pkg::S_R_SCAN_W: state_next = front_q ? dgbf_pkg::S_R_EDGE : dgbf_pkg::S_R_SCAN;
      dgbf_pkg::S_R_EDGE:   state_next = (k_cnt == deg_r) ? dgbf_pkg::S_R_SCAN
                                                          : dgbf_pkg::S_R_EDGE_W;
      dgbf_pkg::S_R_EDGE_W: state_next = dgbf_pkg::S_R_LOAD;
      dgbf_pkg::S_R_LOAD:   state_next = dgbf_pkg::S_R_SUM;
      dgbf_pkg::S_R_SUM:    state_next = dgbf_pkg::S_R_CMP;
      dgbf_pkg::S_R_CMP:    state_next = dgbf_pkg::S_R_EDGE;
      dgbf_pkg::S_R_SWAP:   state_next = dgbf_pkg::S_R_SWAP_W;
      dgbf_pkg::S_R_SWAP_W: begin
        if (!last_i) state_next = dgbf_pkg::S_R_SWAP;
        else state_next = any_next ? dgbf_pkg::S_R_ROUND : dgbf_pkg::S_DONE;
      end
      dgbf_pkg::S_DONE: if (!out_valid || m_tready) state_next = dgbf_pkg::S_IDLE;
      default: state_next = dgbf_pkg::S_IDLE;
    endcase
  end

  // Memory ports.
  always_comb begin
    deg_we = 1'b0;  deg_wa = from_r;  deg_wd = '0;
    adj_we = 1'b0;  adj_wd = adj_q;
    dist_we = 1'b0; dist_wa = vidx;   dist_wd = dgbf_pkg::DIST_UNREACHED;
    front_we = 1'b0; front_wa = vidx; front_wd = 1'b0;
    join_we = 1'b0; join_wa = vidx;   join_wd = 1'b0;
    deg_ra  = list_v;
    join_ra = d_r;
    rd_slot = k_cnt;
    adj_wa  = {from_r, k_cnt[dgbf_pkg::SLOT_W-1:0]};
    case (state)
      dgbf_pkg::S_DISPATCH: begin
        if (kind_r == dgbf_pkg::KIND_ADD_V
            && vertex_total != dgbf_pkg::VT_W'(dgbf_pkg::MAX_VERTICES)) begin
          deg_we  = 1'b1;
          deg_wa  = vertex_total[dgbf_pkg::VID_W-1:0];
          dist_we = 1'b1;
          dist_wa = vertex_total[dgbf_pkg::VID_W-1:0];
        end else if (kind_r == dgbf_pkg::KIND_CLEAR && from_ok) begin
          deg_we = 1'b1;
        end
      end
      dgbf_pkg::S_E_UP: begin
        rd_slot = k_cnt - 1'b1;
        if (k_cnt == pos_r) begin
          adj_we = 1'b1;
          adj_wd.id = to_r;
          adj_wd.weight = weight_r;
          deg_we = 1'b1;
          deg_wd = deg_r + 1'b1;
        end
      end
      dgbf_pkg::S_E_UP_W: begin
        rd_slot = k_cnt - 1'b1;
        adj_we  = 1'b1;
      end
      dgbf_pkg::S_E_DN: begin
        rd_slot = k_cnt + 1'b1;
        if (k_cnt + 1'b1 == deg_r) begin
          deg_we = 1'b1;
          deg_wd = deg_r - 1'b1;
        end
      end
      dgbf_pkg::S_E_DN_W: begin
        rd_slot = k_cnt + 1'b1;
        adj_we  = 1'b1;
      end
      dgbf_pkg::S_R_INIT: begin
        dist_we  = 1'b1;
        dist_wd  = (vidx == from_r) ? '0 : dgbf_pkg::DIST_UNREACHED;
        front_we = 1'b1;
        front_wd = (vidx == from_r);
        join_we  = 1'b1;
      end
      dgbf_pkg::S_R_NEG: begin
        dist_we = 1'b1;
        dist_wd = dgbf_pkg::DIST_NEGATIVE;
      end
      dgbf_pkg::S_R_CMP: begin
        if (dist_b_q > cand_r) begin
          dist_we = 1'b1;
          dist_wa = d_r;
          dist_wd = cand_r;
          if (!join_q) begin
            join_we = 1'b1;
            join_wa = d_r;
            join_wd = 1'b1;
          end
        end
      end
      dgbf_pkg::S_R_SWAP: join_ra = vidx;
      dgbf_pkg::S_R_SWAP_W: begin
        join_ra  = vidx;
        front_we = 1'b1;
        front_wd = join_q;
        join_we  = 1'b1;
      end
      default: ;
    endcase
    adj_ra = {list_v, rd_slot[dgbf_pkg::SLOT_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_q <= deg_mem[deg_ra];
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    adj_q <= adj_mem[adj_ra];
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    dist_a_q <= dist_mem[vidx];
    dist_b_q <= dist_mem[d_r];
    if (front_we) front_mem[front_wa] <= front_wd;
    front_q <= front_mem[vidx];
    if (join_we) join_mem[join_wa] <= join_wd;
    join_q <= join_mem[join_ra];
  end

  // Payload and counters.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r   <= s_tuser;
      from_r   <= s_tdata[9:0];
      to_r     <= s_tdata[19:10];
      weight_r <= s_tdata[40:20];
      d_r      <= s_tdata[9:0];
      status_r <= dgbf_pkg::ST_DONE;
      dist_r   <= '0;
      i_cnt    <= '0;
      k_cnt    <= '0;
      match_r  <= 1'b0;
    end
    case (state)
      dgbf_pkg::S_DISPATCH: begin
        case (kind_r)
          dgbf_pkg::KIND_RUN, dgbf_pkg::KIND_CLEAR, dgbf_pkg::KIND_READ:
            if (!from_ok) status_r <= dgbf_pkg::ST_IGNORED;
          dgbf_pkg::KIND_ADD_E, dgbf_pkg::KIND_REM_E:
            if (!from_ok || !to_ok) status_r <= dgbf_pkg::ST_IGNORED;
          dgbf_pkg::KIND_ADD_V:
            if (vertex_total == dgbf_pkg::VT_W'(dgbf_pkg::MAX_VERTICES))
              status_r <= dgbf_pkg::ST_FULL;
          default: status_r <= dgbf_pkg::ST_IGNORED;
        endcase
      end
      dgbf_pkg::S_E_DEG: deg_r <= deg_q;
      dgbf_pkg::S_E_FIND: pos_r <= k_cnt;
      dgbf_pkg::S_E_FIND_W: begin
        pos_r   <= k_cnt;
        match_r <= (adj_q.id == to_r);
        if (to_r > adj_q.id) k_cnt <= k_cnt + 1'b1;
      end
      dgbf_pkg::S_E_DECIDE: begin
        if (kind_r == dgbf_pkg::KIND_ADD_E) begin
          k_cnt <= deg_r;
          if (!match_r && deg_r == dgbf_pkg::DEG_W'(dgbf_pkg::MAX_DEGREE))
            status_r <= dgbf_pkg::ST_FULL;
        end else begin
          k_cnt <= pos_r;
        end
      end
      dgbf_pkg::S_E_UP_W: k_cnt <= k_cnt - 1'b1;
      dgbf_pkg::S_E_DN_W: k_cnt <= k_cnt + 1'b1;
      dgbf_pkg::S_RD_W:   dist_r <= dist_b_q;
      dgbf_pkg::S_R_INIT: begin
        i_cnt   <= last_i ? '0 : i_cnt + 1'b1;
        round_r <= '0;
      end
      dgbf_pkg::S_R_ROUND: begin
        round_r  <= round_r + 1'b1;
        any_next <= 1'b0;
        i_cnt    <= '0;
      end
      dgbf_pkg::S_R_NEG: i_cnt <= i_cnt + 1'b1;
      dgbf_pkg::S_R_SCAN: if (i_cnt == vertex_total) i_cnt <= '0;
      dgbf_pkg::S_R_SCAN_W: begin
        deg_r <= deg_q;
        k_cnt <= '0;
        if (!front_q) i_cnt <= i_cnt + 1'b1;
      end
      dgbf_pkg::S_R_EDGE: if (k_cnt == deg_r) i_cnt <= i_cnt + 1'b1;
      dgbf_pkg::S_R_EDGE_W: begin
        d_r <= adj_q.id;
        w_r <= adj_q.weight;
      end
      dgbf_pkg::S_R_SUM: cand_r <= sum_sat;
      dgbf_pkg::S_R_CMP: begin
        k_cnt <= k_cnt + 1'b1;
        if (dist_b_q > cand_r && !join_q) any_next <= 1'b1;
      end
      dgbf_pkg::S_R_SWAP_W: i_cnt <= i_cnt + 1'b1;
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dgbf_pkg::S_IDLE;
      vertex_total <= '0;
      last_rounds  <= '0;
      last_cycle   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dgbf_pkg::S_DISPATCH && kind_r == dgbf_pkg::KIND_ADD_V
          && vertex_total != dgbf_pkg::VT_W'(dgbf_pkg::MAX_VERTICES)) begin
        vertex_total <= vertex_total + 1'b1;
      end
      if (state == dgbf_pkg::S_R_NEG && last_i) begin
        last_rounds <= round_r;
        last_cycle  <= 1'b1;
      end
      if (state == dgbf_pkg::S_R_SWAP_W && last_i && !any_next) begin
        last_rounds <= round_r;
        last_cycle  <= 1'b0;
      end
      if (state == dgbf_pkg::S_DONE && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == dgbf_pkg::S_DONE && (!out_valid || m_tready)) begin
      out_status <= status_r;
      out_dist   <= dist_r;
      out_rounds <= last_rounds;
      out_flag   <= last_cycle;
    end
  end

`ifndef NO_ASSERTIONS
  a_neg_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == dgbf_pkg::S_R_NEG && last_i)
    |=> (last_cycle && {1'b0, last_rounds} == {1'b0, vertex_total}))
    else $error("round limit reached with a round count other than the vertex count");

  a_degree_bound: assert property (@(posedge clk) disable iff (rst)
    (state != dgbf_pkg::S_IDLE) |-> (k_cnt <= dgbf_pkg::DEG_W'(dgbf_pkg::MAX_DEGREE)))
    else $error("list slot counter beyond the list capacity");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == dgbf_pkg::S_R_SCAN_W || state == dgbf_pkg::S_R_EDGE)
    |-> (i_cnt < vertex_total))
    else $error("frontier scan beyond the vertex count");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == dgbf_pkg::S_DONE && out_valid && !m_tready) |=> (state == dgbf_pkg::S_DONE))
    else $error("result overwrote a word still waiting at the output");
`endif

endmodule

### tb/sv/dynamic_graph_bellman_ford_sssp_top_tb.sv
// Self-checking testbench for the shortest-path graph engine: edits, runs and reads.
`timescale 1ns / 1ps

module dynamic_graph_bellman_ford_sssp_top_tb;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SMALL_N     = 12;

  typedef struct {
    logic [dgbf_pkg::STAT_W-1:0]        status;
    logic signed [dgbf_pkg::DIST_W-1:0] distance;
    logic [dgbf_pkg::ROUND_W-1:0]       rounds;
    logic                               cycle_flag;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;

  dynamic_graph_bellman_ford_sssp_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the graph and of the last run.
  int                              g_vertices;
  int                              g_degree [dgbf_pkg::MAX_VERTICES];
  logic [dgbf_pkg::VID_W-1:0]      g_head   [dgbf_pkg::MAX_VERTICES][dgbf_pkg::MAX_DEGREE];
  logic signed [dgbf_pkg::W_W-1:0] g_weight [dgbf_pkg::MAX_VERTICES][dgbf_pkg::MAX_DEGREE];
  longint                          g_dist   [dgbf_pkg::MAX_VERTICES];
  logic [dgbf_pkg::ROUND_W-1:0]    g_rounds;
  logic                            g_cycle;

  reply_t pending_replies[$];
  int     error_count = 0;
  int     cycle_count = 0;
  int     hold_cycles = 0;
  int     burst_left  = 0;

  task automatic relax_from(input int src);
    bit     frontier [dgbf_pkg::MAX_VERTICES];
    bit     joined   [dgbf_pkg::MAX_VERTICES];
    int     n, active, round, next, d;
    longint cand;
    n = g_vertices;
    for (int i = 0; i < n; i++) begin
      g_dist[i] = dgbf_pkg::DIST_UNREACHED;
      frontier[i] = 0;
      joined[i] = 0;
    end
    g_dist[src] = 0;
    frontier[src] = 1;
    active = 1;
    round = 0;
    g_cycle = 1'b0;
    while (active != 0) begin
      next = 0;
      round++;
      if (round == n) begin
        for (int i = 0; i < n; i++) g_dist[i] = dgbf_pkg::DIST_NEGATIVE;
        g_cycle = 1'b1;
        break;
      end
      for (int i = 0; i < n; i++) begin
        if (!frontier[i]) continue;
        for (int k = 0; k < g_degree[i]; k++) begin
          d = g_head[i][k];
          cand = g_dist[i] + longint'(g_weight[i][k]);
          if (cand > dgbf_pkg::DIST_UNREACHED) cand = dgbf_pkg::DIST_UNREACHED;
          if (cand < dgbf_pkg::DIST_NEGATIVE) cand = dgbf_pkg::DIST_NEGATIVE;
          if (g_dist[d] > cand) begin
            g_dist[d] = cand;
            if (!joined[d]) begin
              joined[d] = 1;
              next++;
            end
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        frontier[i] = joined[i];
        joined[i] = 0;
      end
      active = next;
    end
    g_rounds = dgbf_pkg::ROUND_W'(round);
  endtask

  task automatic apply_item(input logic [2:0] kind, input int from, input int to,
                            input logic signed [dgbf_pkg::W_W-1:0] w, output reply_t r);
    bit from_ok, to_ok;
    int pos, deg;
    r.status = dgbf_pkg::ST_DONE;
    r.distance = '0;
    from_ok = from < g_vertices;
    to_ok = to < g_vertices;
    if (kind == dgbf_pkg::KIND_RUN) begin
      if (!from_ok) r.status = dgbf_pkg::ST_IGNORED;
      else relax_from(from);
    end else if (kind == dgbf_pkg::KIND_ADD_E || kind == dgbf_pkg::KIND_REM_E) begin
      if (!from_ok || !to_ok) begin
        r.status = dgbf_pkg::ST_IGNORED;
      end else begin
        deg = g_degree[from];
        pos = 0;
        while (pos < deg && g_head[from][pos] < to) pos++;
        if (pos < deg && g_head[from][pos] == to) begin
          if (kind == dgbf_pkg::KIND_REM_E) begin
            for (int k = pos; k + 1 < deg; k++) begin
              g_head[from][k] = g_head[from][k+1];
              g_weight[from][k] = g_weight[from][k+1];
            end
            g_degree[from] = deg - 1;
          end
        end else if (kind == dgbf_pkg::KIND_ADD_E) begin
          if (deg >= dgbf_pkg::MAX_DEGREE) begin
            r.status = dgbf_pkg::ST_FULL;
          end else begin
            for (int k = deg; k > pos; k--) begin
              g_head[from][k] = g_head[from][k-1];
              g_weight[from][k] = g_weight[from][k-1];
            end
            g_head[from][pos] = dgbf_pkg::VID_W'(to);
            g_weight[from][pos] = w;
            g_degree[from] = deg + 1;
          end
        end
      end
    end else if (kind == dgbf_pkg::KIND_ADD_V) begin
      if (g_vertices >= dgbf_pkg::MAX_VERTICES) begin
        r.status = dgbf_pkg::ST_FULL;
      end else begin
        g_degree[g_vertices] = 0;
        g_dist[g_vertices] = dgbf_pkg::DIST_UNREACHED;
        g_vertices++;
      end
    end else if (kind == dgbf_pkg::KIND_CLEAR) begin
      if (!from_ok) r.status = dgbf_pkg::ST_IGNORED;
      else g_degree[from] = 0;
    end else if (kind == dgbf_pkg::KIND_READ) begin
      if (!from_ok) r.status = dgbf_pkg::ST_IGNORED;
      else r.distance = dgbf_pkg::DIST_W'(g_dist[from]);
    end else begin
      r.status = dgbf_pkg::ST_IGNORED;
    end
    r.rounds = g_rounds;
    r.cycle_flag = g_cycle;
  endtask

  // Called at a falling edge; returns at a falling edge with the word accepted.
  task automatic send_item(input logic [2:0] kind, input int from, input int to,
                           input int w);
    reply_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7)) begin
        s_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tuser = kind;
    s_tdata = {7'b0, dgbf_pkg::W_W'(w), to[9:0], from[9:0]};
    do @(posedge clk); while (!s_tready);
    apply_item(kind, from, to, dgbf_pkg::W_W'(w), r);
    pending_replies.push_back(r);
    @(negedge clk);
  endtask

  task automatic drain_replies();
    s_tvalid = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case ((cycle_count / 300) % 3)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    reply_t e;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dynamic_graph_bellman_ford_sssp_top_tb: done, errors");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result word");
        error_count++;
      end else begin
        e = pending_replies.pop_front();
        if (m_tuser !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, m_tuser);
          error_count++;
        end
        if ($signed(m_tdata[30:0]) !== e.distance) begin
          $error("distance: expected %0d, got %0d", e.distance, $signed(m_tdata[30:0]));
          error_count++;
        end
        if (m_tdata[41:31] !== e.rounds) begin
          $error("rounds: expected %0d, got %0d", e.rounds, m_tdata[41:31]);
          error_count++;
        end
        if (m_tdata[42] !== e.cycle_flag) begin
          $error("negative_cycle: expected %0d, got %0d", e.cycle_flag, m_tdata[42]);
          error_count++;
        end
      end
    end
  end

  function automatic int pick_weight();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return int'($urandom_range(0, 50));
    if (sel < 80) return -int'($urandom_range(1, 8));
    return $signed(dgbf_pkg::W_W'($urandom));
  endfunction

  task automatic test_empty_and_single();
    send_item(dgbf_pkg::KIND_READ, 0, 0, 0);
    send_item(dgbf_pkg::KIND_RUN, 0, 0, 0);
    send_item(dgbf_pkg::KIND_ADD_E, 0, 0, 5);
    send_item(3'd6, 0, 0, 0);
    send_item(3'd7, 1023, 1023, -1);
    send_item(dgbf_pkg::KIND_ADD_V, 1023, 0, 0);
    // A lone vertex reaches the round limit on its first round.
    send_item(dgbf_pkg::KIND_RUN, 0, 0, 0);
    send_item(dgbf_pkg::KIND_READ, 0, 0, 0);
    drain_replies();
  endtask

  task automatic test_list_edits();
    repeat (3) send_item(dgbf_pkg::KIND_ADD_V, 0, 0, 0);
    send_item(dgbf_pkg::KIND_ADD_E, 0, 3, 1048575);
    send_item(dgbf_pkg::KIND_ADD_E, 0, 1, -1048576);
    send_item(dgbf_pkg::KIND_ADD_E, 0, 2, 7);
    send_item(dgbf_pkg::KIND_ADD_E, 0, 2, 99);
    send_item(dgbf_pkg::KIND_REM_E, 0, 1, 0);
    send_item(dgbf_pkg::KIND_REM_E, 0, 1, 0);
    send_item(dgbf_pkg::KIND_ADD_E, 2, 1, 3);
    send_item(dgbf_pkg::KIND_ADD_E, 0, 4, 3);
    send_item(dgbf_pkg::KIND_RUN, 0, 0, 0);
    for (int v = 0; v < 4; v++) send_item(dgbf_pkg::KIND_READ, v, 0, 0);
    send_item(dgbf_pkg::KIND_CLEAR, 0, 0, 0);
    send_item(dgbf_pkg::KIND_READ, 3, 0, 0);
    drain_replies();
  endtask

  task automatic test_negative_loop();
    send_item(dgbf_pkg::KIND_ADD_E, 1, 2, -5);
    send_item(dgbf_pkg::KIND_ADD_E, 2, 1, 2);
    send_item(dgbf_pkg::KIND_ADD_E, 0, 1, 1);
    send_item(dgbf_pkg::KIND_RUN, 0, 0, 0);
    send_item(dgbf_pkg::KIND_READ, 2, 0, 0);
    send_item(dgbf_pkg::KIND_RUN, 3, 0, 0);
    send_item(dgbf_pkg::KIND_READ, 3, 0, 0);
    drain_replies();
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    for (int i = 0; i < 20; i++) send_item(dgbf_pkg::KIND_READ, $urandom_range(0, 4), 0, 0);
    drain_replies();
  endtask

  task automatic test_random_traffic();
    int sel, from, to;
    for (int i = 0; i < 600; i++) begin
      sel = $urandom_range(0, 99);
      from = $urandom_range(0, g_vertices - 1);
      to = $urandom_range(0, g_vertices - 1);
      if ($urandom_range(0, 19) == 0) from = $urandom_range(0, 1023);
      if ($urandom_range(0, 19) == 0) to = $urandom_range(0, 1023);
      if (sel < 40) send_item(dgbf_pkg::KIND_ADD_E, from, to, pick_weight());
      else if (sel < 50) send_item(dgbf_pkg::KIND_REM_E, from, to, pick_weight());
      else if (sel < 60) send_item(dgbf_pkg::KIND_RUN, from, to, pick_weight());
      else if (sel < 82) send_item(dgbf_pkg::KIND_READ, from, to, pick_weight());
      else if (sel < 87) send_item(dgbf_pkg::KIND_CLEAR, from, to, pick_weight());
      else if (sel < 97) begin
        if (g_vertices < SMALL_N) send_item(dgbf_pkg::KIND_ADD_V, from, to, pick_weight());
        else send_item(dgbf_pkg::KIND_READ, from, to, pick_weight());
      end else send_item(3'($urandom_range(6, 7)), from, to, pick_weight());
    end
    drain_replies();
  endtask

  task automatic test_full_tables();
    // Clear any loops first: a run over a large graph must stay short.
    for (int v = 0; v < g_vertices; v++) send_item(dgbf_pkg::KIND_CLEAR, v, 0, 0);
    while (g_vertices < dgbf_pkg::MAX_VERTICES) send_item(dgbf_pkg::KIND_ADD_V, 0, 0, 0);
    send_item(dgbf_pkg::KIND_ADD_V, 0, 0, 0);
    send_item(dgbf_pkg::KIND_READ, 1023, 0, 0);
    for (int k = 16; k >= 0; k--) send_item(dgbf_pkg::KIND_ADD_E, 1023, 1000 + k, k + 1);
    send_item(dgbf_pkg::KIND_ADD_E, 1023, 1003, 50);
    send_item(dgbf_pkg::KIND_ADD_E, 0, 1023, 1048575);
    send_item(dgbf_pkg::KIND_RUN, 0, 0, 0);
    send_item(dgbf_pkg::KIND_READ, 1023, 0, 0);
    send_item(dgbf_pkg::KIND_READ, 1010, 0, 0);
    send_item(dgbf_pkg::KIND_READ, 1016, 0, 0);
    drain_replies();
  endtask

  initial begin
    g_vertices = 0;
    g_rounds = '0;
    g_cycle = 1'b0;
    for (int i = 0; i < dgbf_pkg::MAX_VERTICES; i++) begin
      g_degree[i] = 0;
      g_dist[i] = dgbf_pkg::DIST_UNREACHED;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_and_single();
    test_list_edits();
    test_negative_loop();
    test_backpressure();
    test_random_traffic();
    test_full_tables();
    if (error_count == 0) begin
      $display("dynamic_graph_bellman_ford_sssp_top_tb: done, clean");
    end else begin
      $display("dynamic_graph_bellman_ford_sssp_top_tb: done, errors");
    end
    $finish;
  end

endmodule
